### hw/rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int KEY_W         = 10;
  localparam int CAP_W         = 7;
  localparam int DEPTH_DEF     = 64;
  localparam int TAG_WIDTH_DEF = 16;

  localparam logic [KEY_W-1:0] KEY_LIMIT = 10'd1000;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [1:0] ST_INVALID   = 2'd3;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [KEY_W-1:0] key;
  } spq_ctrl_t;

endpackage

### hw/rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry, shifts toward the tail on an
// insert ahead of it and toward the head on a remove.
// ----------------------------------------------------------------------------
module spq_cell #(
  parameter int TAG_WIDTH = spq_pkg::TAG_WIDTH_DEF
) (
  input  logic                     clk,
  input  spq_pkg::spq_ctrl_t       ctrl,
  input  logic [TAG_WIDTH-1:0]     new_tag,
  input  logic                     occ,
  input  logic                     left_gt,
  input  logic [spq_pkg::KEY_W-1:0] left_key,
  input  logic [TAG_WIDTH-1:0]     left_tag,
  input  logic [spq_pkg::KEY_W-1:0] right_key,
  input  logic [TAG_WIDTH-1:0]     right_tag,
  output logic [spq_pkg::KEY_W-1:0] key,
  output logic [TAG_WIDTH-1:0]     tag,
  output logic                     gt
);

  logic [spq_pkg::KEY_W-1:0] key_next;
  logic [TAG_WIDTH-1:0]      tag_next;

  // new entry belongs at or before this slot
  assign gt = !occ || (ctrl.key > key);

  always_comb begin
    key_next = key;
    tag_next = tag;
    if (ctrl.ins && gt) begin
      if (left_gt) begin
        key_next = left_key;
        tag_next = left_tag;
      end else begin
        key_next = ctrl.key;
        tag_next = new_tag;
      end
    end else if (ctrl.rem) begin
      key_next = right_key;
      tag_next = right_tag;
    end
  end

  always_ff @(posedge clk) begin
    key <= key_next;
    tag <= tag_next;
  end

endmodule

### hw/rtl/spq_rsp_buf.sv
// ----------------------------------------------------------------------------
// spq_rsp_buf
// Output register with a skid stage for the result channel.
// ----------------------------------------------------------------------------
module spq_rsp_buf #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [W-1:0] out_data
);

  logic         skid_valid;
  logic [W-1:0] skid_data;
  logic         take;
  logic         accept;

  assign in_stall = skid_valid;
  assign take     = out_valid && !out_stall;
  assign accept   = in_valid && !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid || take) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        out_data <= skid_data;
      end
    end else if (accept) begin
      if (!out_valid || take) begin
        out_data <= in_data;
      end else begin
        skid_data <= in_data;
      end
    end
  end

endmodule

### hw/rtl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Priority queue kept sorted by descending key in a chain of cells; equal
// keys keep arrival order.
//
//   channel   dir  handshake            payload
//   req       in   req_valid/req_stall  kind, key, tag
//   rsp       out  rsp_valid/rsp_stall  status, out_key, out_tag, count
//   capacity  in   capacity_wr          capacity
//
// One beat per cycle while req_stall is low: every cell compares against the new
// key at once and shifts in the same cycle. The result is registered in spq_rsp_buf.
// A stalled rsp beat is held; one more req beat is taken into a skid stage,
// then req_stall rises. Reset clears the count and capacity is 64; no clearing pass.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
  parameter int DEPTH     = spq_pkg::DEPTH_DEF,
  parameter int TAG_WIDTH = spq_pkg::TAG_WIDTH_DEF,
  parameter int CNT_W     = $clog2(DEPTH + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      capacity_wr,
  input  logic [spq_pkg::CAP_W-1:0] capacity,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  logic                      kind,
  input  logic [spq_pkg::KEY_W-1:0] key,
  input  logic [TAG_WIDTH-1:0]      tag,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output logic [1:0]                status,
  output logic [spq_pkg::KEY_W-1:0] out_key,
  output logic [TAG_WIDTH-1:0]      out_tag,
  output logic [CNT_W-1:0]          count
);

  localparam int CMP_W = (CNT_W > spq_pkg::CAP_W) ? CNT_W : spq_pkg::CAP_W;
  localparam int RSP_W = 2 + spq_pkg::KEY_W + TAG_WIDTH + CNT_W;

  logic [spq_pkg::CAP_W-1:0] cap_reg;
  logic [CNT_W-1:0]          entries;
  logic [CNT_W-1:0]          entries_next;
  logic [CMP_W-1:0]          limit;
  logic                      accept;
  logic                      full;
  logic [1:0]                st;
  logic                      do_ins;
  logic                      do_rem;
  logic [spq_pkg::KEY_W-1:0] rk;
  logic [TAG_WIDTH-1:0]      rt;
  logic [RSP_W-1:0]          rsp_in;
  logic [RSP_W-1:0]          rsp_out;
  spq_pkg::spq_ctrl_t        ctrl;

  logic [spq_pkg::KEY_W-1:0] cell_key [DEPTH];
  logic [TAG_WIDTH-1:0]      cell_tag [DEPTH];
  logic                      cell_gt  [DEPTH];

  assign limit = (CMP_W'(cap_reg) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(cap_reg);
  assign full  = CMP_W'(entries) >= limit;

  always_comb begin
    unique case (kind)
      spq_pkg::KIND_INSERT: begin
        if (full) begin
          st = spq_pkg::ST_OVERFLOW;
        end else if (key >= spq_pkg::KEY_LIMIT) begin
          st = spq_pkg::ST_INVALID;
        end else begin
          st = spq_pkg::ST_OK;
        end
      end
      spq_pkg::KIND_REMOVE: begin
        st = (entries == '0) ? spq_pkg::ST_UNDERFLOW : spq_pkg::ST_OK;
      end
      default: st = spq_pkg::ST_OK;
    endcase
  end

  assign do_ins = accept && (kind == spq_pkg::KIND_INSERT) && (st == spq_pkg::ST_OK);
  assign do_rem = accept && (kind == spq_pkg::KIND_REMOVE) && (st == spq_pkg::ST_OK);

  always_comb begin
    entries_next = entries;
    if (do_ins) begin
      entries_next = entries + CNT_W'(1);
    end else if (do_rem) begin
      entries_next = entries - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entries <= '0;
      cap_reg <= spq_pkg::CAP_RESET;
    end else begin
      entries <= entries_next;
      if (capacity_wr) begin
        cap_reg <= capacity;
      end
    end
  end

  assign ctrl.ins = do_ins;
  assign ctrl.rem = do_rem;
  assign ctrl.key = key;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [spq_pkg::KEY_W-1:0] lk;
    logic [TAG_WIDTH-1:0]      lt;
    logic                      lg;
    logic [spq_pkg::KEY_W-1:0] rkey;
    logic [TAG_WIDTH-1:0]      rtag;

    if (i == 0) begin : g_head
      assign lk = key;
      assign lt = tag;
      assign lg = 1'b0;
    end else begin : g_body
      assign lk = cell_key[i-1];
      assign lt = cell_tag[i-1];
      assign lg = cell_gt[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign rkey = cell_key[i];
      assign rtag = cell_tag[i];
    end else begin : g_mid
      assign rkey = cell_key[i+1];
      assign rtag = cell_tag[i+1];
    end

    spq_cell #(
      .TAG_WIDTH (TAG_WIDTH)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .new_tag   (tag),
      .occ       (CNT_W'(i) < entries),
      .left_gt   (lg),
      .left_key  (lk),
      .left_tag  (lt),
      .right_key (rkey),
      .right_tag (rtag),
      .key       (cell_key[i]),
      .tag       (cell_tag[i]),
      .gt        (cell_gt[i])
    );
  end

  assign rk     = do_rem ? cell_key[0] : '0;
  assign rt     = do_rem ? cell_tag[0] : '0;
  assign rsp_in = {st, rk, rt, entries_next};

  spq_rsp_buf #(
    .W (RSP_W)
  ) u_rsp_buf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req_valid),
    .in_stall  (req_stall),
    .in_data   (rsp_in),
    .out_valid (rsp_valid),
    .out_stall (rsp_stall),
    .out_data  (rsp_out)
  );

  assign accept = req_valid && !req_stall;
  assign {status, out_key, out_tag, count} = rsp_out;

endmodule

### hw/rtl/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks of the sorted priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module spq_checker #(
  parameter int DEPTH     = spq_pkg::DEPTH_DEF,
  parameter int TAG_WIDTH = spq_pkg::TAG_WIDTH_DEF,
  parameter int CNT_W     = $clog2(DEPTH + 1)
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      rsp_valid,
  input logic                      rsp_stall,
  input logic [1:0]                status,
  input logic [spq_pkg::KEY_W-1:0] out_key,
  input logic [TAG_WIDTH-1:0]      out_tag,
  input logic [CNT_W-1:0]          count
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("rsp_valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(out_key)
      && $stable(out_tag) && $stable(count))
    else $error("stalled rsp beat changed");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> count <= CNT_W'(DEPTH))
    else $error("count above depth");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != spq_pkg::ST_OK |-> out_key == '0 && out_tag == '0)
    else $error("failed beat carries an entry");

  a_underflow_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == spq_pkg::ST_UNDERFLOW |-> count == '0)
    else $error("underflow with entries held");

endmodule

bind sorted_priority_queue spq_checker #(
  .DEPTH     (DEPTH),
  .TAG_WIDTH (TAG_WIDTH),
  .CNT_W     (CNT_W)
) u_spq_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .status    (status),
  .out_key   (out_key),
  .out_tag   (out_tag),
  .count     (count)
);

### sim/tb_sorted_priority_queue.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue
// Self-checking bench for the sorted priority queue. Drives insert and remove
// beats in random bursts while the response side stalls on its own pattern.
// A scoreboard tracks the sorted entries and the capacity, predicts status,
// removed entry and count for every accepted request, and checks each
// response beat in order. The capacity is rewritten between phases, only
// while no response is outstanding.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue;
  import spq_pkg::*;

  localparam int TAG_W      = TAG_WIDTH_DEF;
  localparam int CNT_W      = $clog2(DEPTH_DEF + 1);
  localparam int IDLE_LIMIT = 2000;
  localparam int N_PHASES   = 12;

  typedef struct packed {
    logic [1:0]       status;
    logic [KEY_W-1:0] removed_key;
    logic [TAG_W-1:0] removed_tag;
    logic [CNT_W-1:0] held;
  } spq_result_t;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  class queue_scoreboard;
    logic [KEY_W-1:0] held_keys[$];
    logic [TAG_W-1:0] held_tags[$];
    int unsigned      cap_limit;
    spq_result_t      expected[$];
    int               errors;

    function new();
      cap_limit = 32'(CAP_RESET);
      errors    = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] v);
      cap_limit = (v > DEPTH_DEF) ? DEPTH_DEF : 32'(v);
    endfunction

    function void note_request(logic op, logic [KEY_W-1:0] k, logic [TAG_W-1:0] t);
      spq_result_t r;
      int          pos;
      r = '0;
      r.status = ST_OK;
      if (op == KIND_INSERT) begin
        if (held_keys.size() >= cap_limit) begin
          r.status = ST_OVERFLOW;
        end else if (k >= KEY_LIMIT) begin
          r.status = ST_INVALID;
        end else begin
          // place behind every entry with a greater or equal key
          pos = held_keys.size();
          for (int i = 0; i < held_keys.size(); i++) begin
            if (pos == held_keys.size() && k > held_keys[i]) pos = i;
          end
          held_keys.insert(pos, k);
          held_tags.insert(pos, t);
        end
      end else if (held_keys.size() == 0) begin
        r.status = ST_UNDERFLOW;
      end else begin
        r.removed_key = held_keys.pop_front();
        r.removed_tag = held_tags.pop_front();
      end
      r.held = CNT_W'(held_keys.size());
      expected.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_response(spq_result_t got);
      spq_result_t want;
      if (expected.size() == 0) begin
        $display("%0t: response beat expected none actual %p", $time, got);
        errors++;
        return;
      end
      want = expected.pop_front();
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("out_key", 32'(want.removed_key), 32'(got.removed_key));
      compare_field("out_tag", 32'(want.removed_tag), 32'(got.removed_tag));
      compare_field("count", 32'(want.held), 32'(got.held));
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             capacity_wr = 1'b0;
  logic [CAP_W-1:0] capacity = '0;
  logic             req_valid = 1'b0;
  logic             req_stall;
  logic             kind = KIND_INSERT;
  logic [KEY_W-1:0] key = '0;
  logic [TAG_W-1:0] tag = '0;
  logic             rsp_valid;
  logic             rsp_stall = 1'b0;
  logic [1:0]       status;
  logic [KEY_W-1:0] out_key;
  logic [TAG_W-1:0] out_tag;
  logic [CNT_W-1:0] count;

  queue_scoreboard sb;
  int              req_beats = 0;
  int              idle_cycles = 0;
  int              stall_left = 0;
  stall_mode_t     stall_mode = STALL_NONE;

  sorted_priority_queue #(
    .DEPTH     (DEPTH_DEF),
    .TAG_WIDTH (TAG_W)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .capacity_wr (capacity_wr),
    .capacity    (capacity),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .kind        (kind),
    .key         (key),
    .tag         (tag),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .status      (status),
    .out_key     (out_key),
    .out_tag     (out_tag),
    .count       (count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // sample beats on both channels
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        sb.check_response(spq_result_t'({status, out_key, out_tag, count}));
      end
      if (req_valid && !req_stall) begin
        sb.note_request(kind, key, tag);
        req_beats++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_sorted_priority_queue: FAIL");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(16, 96);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      STALL_NONE:  rsp_stall <= 1'b0;
      STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
      default:     rsp_stall <= ((stall_left % 5) < 2);
    endcase
  end

  // call at a falling edge; returns at the falling edge after the beat
  task automatic send_op(input logic op, input logic [KEY_W-1:0] k,
                         input logic [TAG_W-1:0] t);
    int seen;
    seen = req_beats;
    req_valid <= 1'b1;
    kind      <= op;
    key       <= k;
    tag       <= t;
    do @(negedge clk); while (req_beats == seen);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] v);
    while (sb.expected.size() != 0) @(negedge clk);
    capacity_wr <= 1'b1;
    capacity    <= v;
    sb.set_capacity(v);
    @(negedge clk);
    capacity_wr <= 1'b0;
  endtask

  task automatic send_random(input int remove_pct);
    logic             op;
    logic [KEY_W-1:0] k;
    int               pick;
    op   = ($urandom_range(0, 99) < remove_pct) ? KIND_REMOVE : KIND_INSERT;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      // narrow range for many equal keys
      k = KEY_W'($urandom_range(0, 15));
    end else if (pick < 9) begin
      k = KEY_W'($urandom_range(0, KEY_LIMIT - 1));
    end else begin
      k = KEY_W'($urandom_range(KEY_LIMIT, (1 << KEY_W) - 1));
    end
    send_op(op, k, TAG_W'($urandom));
  endtask

  task automatic run_phase(input int n_items, input int pct_lo, input int pct_hi);
    int left;
    int burst;
    int gap;
    int pct;
    left = n_items;
    while (left > 0) begin
      burst = $urandom_range(1, 16);
      if (burst > left) burst = left;
      pct = $urandom_range(pct_lo, pct_hi);
      repeat (burst) send_random(pct);
      left -= burst;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    req_valid <= 1'b0;
  endtask

  initial begin
    int caps[N_PHASES] = '{127, 127, 1, 64, 3, 64, 100, -1, -1, -1, 0, 64};
    int lens[N_PHASES] = '{150, 100, 80, 150, 100, 100, 100, 100, 100, 100, 50, 100};
    int lo[N_PHASES]   = '{10, 65, 40, 10, 40, 40, 40, 30, 40, 50, 40, 65};
    int hi[N_PHASES]   = '{35, 90, 60, 35, 60, 60, 60, 50, 60, 70, 60, 90};

    sb = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset capacity: empty remove, key and tag extremes, invalid keys, ties
    send_op(KIND_REMOVE, '1, '1);
    send_op(KIND_INSERT, '0, '0);
    send_op(KIND_INSERT, KEY_LIMIT - 10'd1, '1);
    send_op(KIND_INSERT, KEY_LIMIT, 16'h5a5a);
    send_op(KIND_INSERT, '1, 16'ha5a5);
    send_op(KIND_INSERT, 10'd500, 16'd1);
    send_op(KIND_INSERT, 10'd500, 16'd2);
    send_op(KIND_INSERT, 10'd500, 16'd3);
    send_op(KIND_INSERT, KEY_LIMIT - 10'd1, 16'haaaa);
    send_op(KIND_INSERT, 10'd1, 16'h1234);
    repeat (8) send_op(KIND_REMOVE, '0, '0);
    req_valid <= 1'b0;

    // full queue wins over an invalid key
    write_capacity(7'd2);
    send_op(KIND_INSERT, 10'd10, 16'h0010);
    send_op(KIND_INSERT, 10'd20, 16'h0020);
    send_op(KIND_INSERT, '1, 16'hffff);
    send_op(KIND_INSERT, 10'd5, 16'h0005);
    req_valid <= 1'b0;

    // zero capacity with entries still held
    write_capacity('0);
    send_op(KIND_INSERT, 10'd7, 16'h0007);
    send_op(KIND_REMOVE, '0, '0);
    send_op(KIND_REMOVE, '0, '0);
    send_op(KIND_REMOVE, '0, '0);
    req_valid <= 1'b0;

    for (int p = 0; p < N_PHASES; p++) begin
      if (caps[p] < 0) begin
        write_capacity(CAP_W'($urandom_range(0, (1 << CAP_W) - 1)));
      end else begin
        write_capacity(CAP_W'(caps[p]));
      end
      run_phase(lens[p], lo[p], hi[p]);
    end

    while (sb.expected.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (sb.errors == 0) begin
      $display("tb_sorted_priority_queue: PASS");
    end else begin
      $display("tb_sorted_priority_queue: FAIL");
    end
    $finish;
  end

endmodule
